[src/atl_pkg.sv]
// Shared types, constants and the arctangent table for the tilt angle unit.
package atl_pkg;

    localparam int WORD_W    = 16;
    localparam int SAMPLE_W  = 14;
    localparam int ACC_FRAC  = 24;
    localparam int XY_W      = SAMPLE_W + ACC_FRAC + 4;
    localparam int ACC_W     = 32;
    localparam int OUT_W     = 17;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        logic                    num_neg;
        logic                    den_neg;
        logic                    num_zero;
        logic                    den_zero;
    } t_chan;

    typedef struct packed {
        t_chan pitch;
        t_chan roll;
    } t_work;

    function automatic t_chan chan_init(input logic signed [SAMPLE_W-1:0] num,
                                        input logic signed [SAMPLE_W-1:0] den);
        t_chan                c;
        logic [SAMPLE_W-1:0]  a;
        logic [SAMPLE_W-1:0]  b;
        a = den[SAMPLE_W-1] ? SAMPLE_W'(-den) : SAMPLE_W'(den);
        b = num[SAMPLE_W-1] ? SAMPLE_W'(-num) : SAMPLE_W'(num);
        c = '0;
        c.x[ACC_FRAC +: SAMPLE_W] = a;
        c.y[ACC_FRAC +: SAMPLE_W] = b;
        c.num_neg  = num[SAMPLE_W-1];
        c.den_neg  = den[SAMPLE_W-1];
        c.num_zero = (num == '0);
        c.den_zero = (den == '0);
        return c;
    endfunction

endpackage

[src/atl_prep.sv]
// Input stage: unpacks the register words and seeds both vectoring channels.
module atl_prep (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [atl_pkg::WORD_W-1:0] i_accel_x_word,
    input  logic [atl_pkg::WORD_W-1:0] i_accel_y_word,
    input  logic [atl_pkg::WORD_W-1:0] i_accel_z_word,
    output logic                       o_valid,
    input  logic                       i_ready,
    output atl_pkg::t_work             o_data
);

    logic                                   r_valid;
    atl_pkg::t_work                         r_data;
    atl_pkg::t_work                         n_data;
    logic signed [atl_pkg::SAMPLE_W-1:0]    sx;
    logic signed [atl_pkg::SAMPLE_W-1:0]    sy;
    logic signed [atl_pkg::SAMPLE_W-1:0]    sz;

    assign sx = $signed(i_accel_x_word[atl_pkg::WORD_W-1:2]);
    assign sy = $signed(i_accel_y_word[atl_pkg::WORD_W-1:2]);
    assign sz = $signed(i_accel_z_word[atl_pkg::WORD_W-1:2]);

    always_comb begin
        n_data.pitch = atl_pkg::chan_init(sy, sz);
        n_data.roll  = atl_pkg::chan_init(sx, sz);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    a_zero_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.pitch.num_zero == (r_data.pitch.y == '0))
                 && (r_data.roll.num_zero == (r_data.roll.y == '0)))
        else $error("Zero flag disagrees with the seeded magnitude.");

endmodule

[src/atl_cordic_stage.sv]
// One registered CORDIC vectoring iteration for the pitch and roll channels.
module atl_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  atl_pkg::t_work i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output atl_pkg::t_work o_data
);

    localparam logic signed [atl_pkg::ACC_W-1:0] ATAN_STEP = atl_pkg::ATAN_TAB[SHIFT];

    logic           r_valid;
    atl_pkg::t_work r_data;
    atl_pkg::t_work n_data;

    function automatic atl_pkg::t_chan rotate(input atl_pkg::t_chan c);
        atl_pkg::t_chan                    r;
        logic signed [atl_pkg::XY_W-1:0]   dx;
        logic signed [atl_pkg::XY_W-1:0]   dy;
        dx = $signed(c.y) >>> SHIFT;
        dy = $signed(c.x) >>> SHIFT;
        r  = c;
        if (!c.y[atl_pkg::XY_W-1]) begin
            r.x   = c.x + dx;
            r.y   = c.y - dy;
            r.acc = c.acc + ATAN_STEP;
        end else begin
            r.x   = c.x - dx;
            r.y   = c.y + dy;
            r.acc = c.acc - ATAN_STEP;
        end
        return r;
    endfunction

    always_comb begin
        n_data.pitch = rotate(i_data.pitch);
        n_data.roll  = rotate(i_data.roll);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    a_x_positive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_data.pitch.x[atl_pkg::XY_W-1] && !r_data.roll.x[atl_pkg::XY_W-1])
        else $error("Vector x component went negative.");

endmodule

[src/atl_finish.sv]
// Output stages: clamp and round the angle, then apply quadrant and sign.
module atl_finish #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  atl_pkg::t_work                    i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [atl_pkg::OUT_W-1:0]  o_pitch_deg,
    output logic signed [atl_pkg::OUT_W-1:0]  o_roll_deg
);

    localparam int OW    = atl_pkg::OUT_W;
    localparam int AW    = atl_pkg::ACC_W;
    localparam int MAG_W = ANGLE_FRAC_BITS + 8;
    localparam int ANG_W = ANGLE_FRAC_BITS + 9;
    localparam int DROP  = atl_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic [AW-1:0]    LIM   = AW'(90 * (2 ** atl_pkg::ACC_FRAC));
    localparam logic [AW-1:0]    HALF  = AW'(2 ** (DROP - 1));
    localparam logic [MAG_W-1:0] ONE90 = MAG_W'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [MAG_W-1:0] ONE80 = MAG_W'(180 * (2 ** ANGLE_FRAC_BITS));

    logic                    r_a_valid;
    logic [MAG_W-1:0]        r_a_mag [2];
    logic                    r_a_sub [2];
    logic                    r_a_neg [2];
    logic [MAG_W-1:0]        n_a_mag [2];
    logic                    n_a_sub [2];
    logic                    n_a_neg [2];
    atl_pkg::t_chan          chan    [2];
    logic                    a_ready;

    logic                    r_b_valid;
    logic signed [OW-1:0]    r_b_deg [2];
    logic signed [OW-1:0]    n_b_deg [2];

    assign chan[0] = i_data.pitch;
    assign chan[1] = i_data.roll;

    always_comb begin
        logic [AW-1:0] clamped;
        logic [AW-1:0] rounded;
        for (int ch = 0; ch < 2; ch++) begin
            if (chan[ch].acc[AW-1]) begin
                clamped = '0;
            end else if (chan[ch].acc > $signed(LIM)) begin
                clamped = LIM;
            end else begin
                clamped = chan[ch].acc;
            end
            rounded = (clamped + HALF) >> DROP;
            if (chan[ch].num_zero) begin
                n_a_mag[ch] = chan[ch].den_neg ? ONE80 : '0;
            end else if (chan[ch].den_zero) begin
                n_a_mag[ch] = ONE90;
            end else begin
                n_a_mag[ch] = rounded[MAG_W-1:0];
            end
            n_a_sub[ch] = chan[ch].den_neg && !chan[ch].num_zero;
        end
        n_a_neg[0] = !chan[0].num_neg;
        n_a_neg[1] = chan[1].num_neg;
    end

    always_comb begin
        logic signed [ANG_W-1:0] v;
        logic signed [ANG_W-1:0] ang;
        for (int ch = 0; ch < 2; ch++) begin
            if (r_a_sub[ch]) begin
                v = $signed({1'b0, ONE80}) - $signed({1'b0, r_a_mag[ch]});
            end else begin
                v = $signed({1'b0, r_a_mag[ch]});
            end
            ang = r_a_neg[ch] ? -v : v;
            n_b_deg[ch] = OW'(ang);
        end
    end

    assign o_ready     = !r_a_valid || a_ready;
    assign a_ready     = !r_b_valid || i_ready;
    assign o_valid     = r_b_valid;
    assign o_pitch_deg = r_b_deg[0];
    assign o_roll_deg  = r_b_deg[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_mag <= n_a_mag;
            r_a_sub <= n_a_sub;
            r_a_neg <= n_a_neg;
        end
        if (a_ready && r_a_valid) begin
            r_b_deg <= n_b_deg;
        end
    end

    a_mag_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_mag[0] <= ONE80) && (r_a_mag[1] <= ONE80))
        else $error("Rounded angle magnitude exceeds a half turn.");

    a_sub_quadrant : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && (r_a_sub[0] || r_a_sub[1]) |->
            (!r_a_sub[0] || r_a_mag[0] <= ONE90) && (!r_a_sub[1] || r_a_mag[1] <= ONE90))
        else $error("Quadrant mirror applied to a magnitude above a right angle.");

endmodule

[src/accel_tilt_angles_unit.sv]
// Top level of the accelerometer tilt angle unit: input stage, CORDIC pipeline, output stages.
// Usage: present three accelerometer register words (high byte first, 14-bit
// sample left-justified) on the input channel with i_valid; a word is taken
// when i_valid and o_ready are both high. Each word yields one output word with
// pitch = -atan2(y, z) and roll = atan2(x, z) in degrees, signed, with
// ANGLE_FRAC_BITS fraction bits, on o_valid / i_ready.
// The pipeline is one input stage, one register per CORDIC iteration, and two
// output stages for rounding and quadrant mapping.
// Throughput is one word per cycle while i_ready is high; each stage holds one
// word and passes it on when the next stage is empty or being emptied; bubbles collapse.
// When the receiver stalls, the output register holds its word and the stages
// behind it keep filling until the whole pipeline of CORDIC_STAGES + 3 words is
// full; only then does o_ready drop.
// Reset clears all valid flags; the unit accepts a word in the first cycle
// after reset is released.
module accel_tilt_angles_unit #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [atl_pkg::WORD_W-1:0]        i_accel_x_word,
    input  logic [atl_pkg::WORD_W-1:0]        i_accel_y_word,
    input  logic [atl_pkg::WORD_W-1:0]        i_accel_z_word,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [atl_pkg::OUT_W-1:0]  o_pitch_deg,
    output logic signed [atl_pkg::OUT_W-1:0]  o_roll_deg
);

    atl_pkg::t_work w_data  [CORDIC_STAGES+1];
    logic           w_valid [CORDIC_STAGES+1];
    logic           w_ready [CORDIC_STAGES+1];

    atl_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_accel_x_word (i_accel_x_word),
        .i_accel_y_word (i_accel_y_word),
        .i_accel_z_word (i_accel_z_word),
        .o_valid        (w_valid[0]),
        .i_ready        (w_ready[0]),
        .o_data         (w_data[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        atl_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    atl_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[CORDIC_STAGES]),
        .o_ready     (w_ready[CORDIC_STAGES]),
        .i_data      (w_data[CORDIC_STAGES]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pitch_deg (o_pitch_deg),
        .o_roll_deg  (o_roll_deg)
    );

endmodule

[verif/accel_tilt_angles_checker.sv]
// Checker that predicts the pitch and roll of every accepted word and compares the outputs.
`timescale 1ns / 100ps

module accel_tilt_angles_checker #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [atl_pkg::WORD_W-1:0]        i_accel_x_word,
    input  logic [atl_pkg::WORD_W-1:0]        i_accel_y_word,
    input  logic [atl_pkg::WORD_W-1:0]        i_accel_z_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [atl_pkg::OUT_W-1:0]  i_pitch_deg,
    input  logic signed [atl_pkg::OUT_W-1:0]  i_roll_deg,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int  DROP       = atl_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int  ONE_DEG    = 1 << ANGLE_FRAC_BITS;

    typedef struct packed {
        logic signed [atl_pkg::OUT_W-1:0] pitch;
        logic signed [atl_pkg::OUT_W-1:0] roll;
    } t_tilt;

    t_tilt expected_angles [$];

    function automatic int sensor_sample(input logic [atl_pkg::WORD_W-1:0] w);
        logic signed [atl_pkg::SAMPLE_W-1:0] s;
        s = w[atl_pkg::WORD_W-1 -: atl_pkg::SAMPLE_W];
        return int'(s);
    endfunction

    // Angle of the vector (den, num) in degrees, rounded to ANGLE_FRAC_BITS.
    function automatic int tilt_angle(input int num, input int den);
        longint a;
        longint b;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint acc;
        longint lim;
        int     mag;
        int     i;
        a = (den < 0) ? -longint'(den) : longint'(den);
        b = (num < 0) ? -longint'(num) : longint'(num);
        if (b == 0) begin
            return (den < 0) ? 180 * ONE_DEG : 0;
        end
        if (a == 0) begin
            mag = 90 * ONE_DEG;
        end else begin
            x   = a <<< atl_pkg::ACC_FRAC;
            y   = b <<< atl_pkg::ACC_FRAC;
            acc = 0;
            lim = longint'(90) <<< atl_pkg::ACC_FRAC;
            for (i = 0; i < CORDIC_STAGES && i < atl_pkg::TABLE_LEN; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x   = x + dx;
                    y   = y - dy;
                    acc = acc + longint'(atl_pkg::ATAN_TAB[i]);
                end else begin
                    x   = x - dx;
                    y   = y + dy;
                    acc = acc - longint'(atl_pkg::ATAN_TAB[i]);
                end
            end
            if (acc < 0) acc = 0;
            if (acc > lim) acc = lim;
            mag = int'((acc + (longint'(1) <<< (DROP - 1))) >>> DROP);
        end
        if (den < 0) mag = 180 * ONE_DEG - mag;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_tilt predict_tilt(input logic [atl_pkg::WORD_W-1:0] xw,
                                           input logic [atl_pkg::WORD_W-1:0] yw,
                                           input logic [atl_pkg::WORD_W-1:0] zw);
        t_tilt t;
        int    sx;
        int    sy;
        int    sz;
        sx = sensor_sample(xw);
        sy = sensor_sample(yw);
        sz = sensor_sample(zw);
        t.pitch = atl_pkg::OUT_W'(-tilt_angle(sy, sz));
        t.roll  = atl_pkg::OUT_W'(tilt_angle(sx, sz));
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_tilt want;
        if (!i_rst_n) begin
            expected_angles.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t: output word with none expected, pitch %0d roll %0d",
                             $time, i_pitch_deg, i_roll_deg);
                    o_fail_count++;
                end else begin
                    want = expected_angles.pop_front();
                    if (i_pitch_deg !== want.pitch) begin
                        $display("%0t: pitch mismatch, expected %0d, got %0d",
                                 $time, want.pitch, i_pitch_deg);
                        o_fail_count++;
                    end
                    if (i_roll_deg !== want.roll) begin
                        $display("%0t: roll mismatch, expected %0d, got %0d",
                                 $time, want.roll, i_roll_deg);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_angles.push_back(predict_tilt(i_accel_x_word, i_accel_y_word,
                                                       i_accel_z_word));
            end
        end
        o_pending = expected_angles.size();
    end

endmodule

[verif/tb_accel_tilt_angles_unit.sv]
// Testbench top for the tilt angle unit: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_accel_tilt_angles_unit;

    localparam int STAGES         = 16;
    localparam int FRAC_BITS      = 8;
    localparam int LATENCY        = STAGES + 3;
    localparam int RANDOM_WORDS   = 800;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic [atl_pkg::WORD_W-1:0]         i_accel_x_word;
    logic [atl_pkg::WORD_W-1:0]         i_accel_y_word;
    logic [atl_pkg::WORD_W-1:0]         i_accel_z_word;
    logic                               o_valid;
    logic                               i_ready;
    logic signed [atl_pkg::OUT_W-1:0]   o_pitch_deg;
    logic signed [atl_pkg::OUT_W-1:0]   o_roll_deg;

    int fail_count;
    int pending;
    int stall_cycles;
    bit quiet;

    accel_tilt_angles_unit #(
        .CORDIC_STAGES   (STAGES),
        .ANGLE_FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_accel_x_word (i_accel_x_word),
        .i_accel_y_word (i_accel_y_word),
        .i_accel_z_word (i_accel_z_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pitch_deg    (o_pitch_deg),
        .o_roll_deg     (o_roll_deg)
    );

    accel_tilt_angles_checker #(
        .CORDIC_STAGES   (STAGES),
        .ANGLE_FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_accel_x_word (i_accel_x_word),
        .i_accel_y_word (i_accel_y_word),
        .i_accel_z_word (i_accel_z_word),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_pitch_deg    (o_pitch_deg),
        .i_roll_deg     (o_roll_deg),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("FAIL accel_tilt_angles_unit");
        $finish;
    end

    // Packs a 14-bit sample into a register word with random don't-care low bits.
    function automatic logic [atl_pkg::WORD_W-1:0] to_word(input int s);
        logic [atl_pkg::SAMPLE_W-1:0] v;
        v = atl_pkg::SAMPLE_W'(s);
        return {v, 2'($urandom_range(3))};
    endfunction

    function automatic int gravity_sample();
        return int'($urandom_range(10000)) - 5000;
    endfunction

    function automatic int small_sample();
        return int'($urandom_range(8)) - 4;
    endfunction

    function automatic int corner_sample();
        case ($urandom_range(6))
            0:       return -8192;
            1:       return 8191;
            2:       return -1;
            3:       return 1;
            4:       return 0;
            5:       return -8191;
            default: return 4096;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [atl_pkg::WORD_W-1:0] xw,
                             input logic [atl_pkg::WORD_W-1:0] yw,
                             input logic [atl_pkg::WORD_W-1:0] zw);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_accel_x_word <= xw;
        i_accel_y_word <= yw;
        i_accel_z_word <= zw;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_samples(input int sx, input int sy, input int sz);
        send_word(to_word(sx), to_word(sy), to_word(sz));
    endtask

    initial begin
        int n;
        int sx;
        int sy;
        int sz;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_accel_x_word = '0;
        i_accel_y_word = '0;
        i_accel_z_word = '0;
        quiet          = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_samples(0, 0, 0);
        send_samples(0, 0, -100);
        send_samples(0, 0, 100);
        send_samples(0, 0, -8192);
        send_samples(100, -100, 0);
        send_samples(-8192, 8191, 0);
        send_samples(8191, 8191, 8191);
        send_samples(-8192, -8192, -8192);
        send_samples(8191, -8192, 1);
        send_samples(1, -1, -8192);
        send_samples(-1, 1, 8191);
        send_samples(0, 5, -5);
        send_samples(5, 0, -5);
        send_samples(-3, 7, -8191);
        send_samples(4096, -2048, 4096);
        send_samples(-1, -1, -1);
        send_word(16'hFFFF, 16'h0000, 16'h8000);
        send_word(16'h7FFF, 16'h8000, 16'hFFFF);
        send_word(16'h0003, 16'h0003, 16'h0003);
        send_word(16'h8003, 16'h7FFC, 16'h0004);
        send_word(16'h5555, 16'hAAAA, 16'hFFFC);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= 300 && n < 500);
            case ($urandom_range(9))
                0, 1, 2: begin
                    send_word(16'($urandom), 16'($urandom), 16'($urandom));
                end
                3, 4, 5: begin
                    send_samples(gravity_sample(), gravity_sample(), gravity_sample());
                end
                6: begin
                    send_samples(small_sample(), small_sample(), small_sample());
                end
                7: begin
                    sx = gravity_sample();
                    sy = gravity_sample();
                    sz = gravity_sample();
                    case ($urandom_range(2))
                        0:       sx = 0;
                        1:       sy = 0;
                        default: sz = 0;
                    endcase
                    send_samples(sx, sy, sz);
                end
                default: begin
                    send_samples(corner_sample(), corner_sample(), corner_sample());
                end
            endcase
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS accel_tilt_angles_unit");
        end else begin
            $display("FAIL accel_tilt_angles_unit");
        end
        $finish;
    end

endmodule
